/* hw/rtl/gds_pkg.sv */
// Shared widths, control word layout and microcode addresses for the geometric decay scaler.
// Used by the channel interfaces, the sequencer, the datapath and the top level.
// Depends on nothing else.
package gds_pkg;

  // Payload and configuration widths.
  localparam int unsigned DataW = 64;
  localparam int unsigned DistW = 32;
  localparam int unsigned CfgW  = 7;

  // Decay shift after reset.
  localparam logic [CfgW-1:0] DecayShiftRst = 7'd20;
  // Saturation bounds of the decay shift when the ladder is built.
  localparam logic [CfgW-1:0] DecayShiftMin = 7'd1;
  localparam logic [CfgW-1:0] DecayShiftMax = 7'd64;

  // Default number of ladder entries.
  localparam int unsigned LADDER_STEPS = 26;

  // Fixed-point arithmetic: 32-bit limbs, 96 fraction bits while building.
  localparam int unsigned LimbW  = 32;
  localparam int unsigned GuardW = 96;
  localparam int unsigned AccW   = 2 * GuardW;
  localparam int unsigned ProdW  = 2 * LimbW;
  localparam int unsigned FracW  = 64;

  // Program counter of the microcode.
  localparam int unsigned PcW = 6;
  typedef logic [PcW-1:0] pc_t;

  typedef logic [1:0] limb_sel_t;
  typedef logic [2:0] limb_shift_t;

  // Microcode addresses. Item program first, ladder build program after it.
  localparam pc_t PcIdle     = 6'd0;
  localparam pc_t PcWait     = 6'd1;
  localparam pc_t PcCheck    = 6'd2;
  localparam pc_t PcLoop     = 6'd3;
  localparam pc_t PcLoad     = 6'd4;
  localparam pc_t PcFm0      = 6'd5;
  localparam pc_t PcFm1      = 6'd6;
  localparam pc_t PcFm2      = 6'd7;
  localparam pc_t PcFmDrain  = 6'd8;
  localparam pc_t PcFmWb     = 6'd9;
  localparam pc_t PcSetW     = 6'd10;
  localparam pc_t PcNext     = 6'd11;
  localparam pc_t PcScale    = 6'd12;
  localparam pc_t PcSm0      = 6'd13;
  localparam pc_t PcSm1      = 6'd14;
  localparam pc_t PcSm2      = 6'd15;
  localparam pc_t PcSm3      = 6'd16;
  localparam pc_t PcSmDrain  = 6'd17;
  localparam pc_t PcOut      = 6'd18;
  localparam pc_t PcOutHold  = 6'd19;
  localparam pc_t PcInit     = 6'd20;
  localparam pc_t PcLadderWr = 6'd21;
  localparam pc_t PcSq0      = 6'd22;
  localparam pc_t PcSq1      = 6'd23;
  localparam pc_t PcSq2      = 6'd24;
  localparam pc_t PcSq3      = 6'd25;
  localparam pc_t PcSq4      = 6'd26;
  localparam pc_t PcSq5      = 6'd27;
  localparam pc_t PcSq6      = 6'd28;
  localparam pc_t PcSq7      = 6'd29;
  localparam pc_t PcSq8      = 6'd30;
  localparam pc_t PcSqDrain  = 6'd31;
  localparam pc_t PcSqWb     = 6'd32;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    DP_NOP       = 4'd0,
    DP_CAPTURE   = 4'd1,  // offer the input channel, latch an item on a beat
    DP_LOAD_B    = 4'd2,  // B <= ladder entry, clear accumulator
    DP_SET_W     = 4'd3,  // running weight <= B
    DP_W_ACC     = 4'd4,  // running weight <= 0.64 product from accumulator
    DP_SCALE_LD  = 4'd5,  // A <= magnitude, B <= weight, clear accumulator
    DP_OUT       = 4'd6,  // load the result register when it is free
    DP_INIT_C    = 4'd7,  // A, B <= 1 - 2^-k at 96 fraction bits
    DP_LADDER_WR = 4'd8,  // ladder entry <= top of A, clear accumulator
    DP_C_ACC     = 4'd9   // A, B <= squared value from accumulator
  } dp_op_e;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_CLR  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_e;

  // Jump conditions; a step that does not jump goes to the next address.
  typedef enum logic [3:0] {
    C_NEVER     = 4'd0,
    C_ALWAYS    = 4'd1,
    C_BUILD_REQ = 4'd2,
    C_NO_START  = 4'd3,
    C_SPECIAL   = 4'd4,
    C_BIT_CLEAR = 4'd5,
    C_FIRST     = 4'd6,
    C_NOT_LAST  = 4'd7,
    C_LAST      = 4'd8,
    C_OUT_FREE  = 4'd9
  } cond_e;

  typedef struct packed {
    dp_op_e      dp;
    idx_op_e     idx_op;
    logic        mul_en;
    limb_sel_t   mul_a;
    limb_sel_t   mul_b;
    limb_shift_t mul_sh;
    cond_e       cond;
    pc_t         target;
  } gds_ctrl_t;

  typedef struct packed {
    logic build_req;
    logic start;
    logic special;
    logic bit_clear;
    logic first;
    logic last;
    logic out_busy;
  } gds_status_t;

endpackage

/* hw/rtl/gds_in_if.sv */
// Input channel of the geometric decay scaler: valid, ready, value and distance.
// Depends on gds_pkg for the field widths.
interface gds_in_if;
  import gds_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic        [DistW-1:0] distance;

  modport source (output valid, output value, output distance, input ready);
  modport sink (input valid, input value, input distance, output ready);
endinterface

/* hw/rtl/gds_out_if.sv */
// Result channel of the geometric decay scaler: valid, ready and adjusted_value.
// Depends on gds_pkg for the field width.
interface gds_out_if;
  import gds_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] adjusted_value;

  modport source (output valid, output adjusted_value, input ready);
  modport sink (input valid, input adjusted_value, output ready);
endinterface

/* hw/rtl/geometric_decay_scaler.sv */
// Geometric decay scaler: adjusted_value = value * (1 - 2^-k)^distance, truncated toward zero.
//
// Channels: in_i carries value and distance, out_o carries adjusted_value; a beat moves on a
// rising edge with valid and ready high. cfg_we_i writes decay_shift (k) from cfg_wdata_i.
// Each item is run by a microcode program on one shared 32x32 multiplier; a distance of zero
// or of 2^LADDER_STEPS or more skips the ladder loop. The next input beat is taken in the
// capture step, after the idle step that follows the registering of the result, so one
// item is in flight at a time and a waiting result does not block the next acceptance.
// Reset loads k = 20 and builds the ladder of k-powers by exact 96-bit squaring; a write of
// k starts the same build, and in_i.ready stays low until it is done. When the receiver
// stalls, the result waits in the output register and the sequencer holds in its output
// step until the register is free.
// Depends on gds_pkg, gds_in_if, gds_out_if, gds_sequencer and gds_datapath.
module geometric_decay_scaler #(
  parameter int unsigned LadderSteps = gds_pkg::LADDER_STEPS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gds_in_if.sink                         in_i,
  gds_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [gds_pkg::CfgW-1:0]       cfg_wdata_i
);
  import gds_pkg::*;

  gds_ctrl_t   ctrl;
  gds_status_t status;

  // Microcode control.
  gds_sequencer u_gds_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Arithmetic, ladder and channel registers.
  gds_datapath #(
    .LadderSteps (LadderSteps)
  ) u_gds_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .value_i          (in_i.value),
    .distance_i       (in_i.distance),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .adjusted_value_o (out_o.adjusted_value),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

endmodule

/* hw/rtl/gds_sequencer.sv */
// Microcode sequencer: program counter, control store and jump logic.
// Depends on gds_pkg for the control word, status word and step addresses.
module gds_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gds_pkg::gds_status_t status_i,
  output gds_pkg::gds_ctrl_t   ctrl_o
);
  import gds_pkg::*;

  // Packs one control word.
  function automatic gds_ctrl_t mk(input dp_op_e dp, input idx_op_e io, input logic mul,
                                   input limb_sel_t ma, input limb_sel_t mb,
                                   input limb_shift_t sh, input cond_e c, input pc_t t);
    gds_ctrl_t w;
    w.dp     = dp;
    w.idx_op = io;
    w.mul_en = mul;
    w.mul_a  = ma;
    w.mul_b  = mb;
    w.mul_sh = sh;
    w.cond   = c;
    w.target = t;
    return w;
  endfunction

  // One multiply-accumulate issue of limb A[ma] times limb B[mb] at weight 2^(32*sh).
  function automatic gds_ctrl_t mac(input limb_sel_t ma, input limb_sel_t mb,
                                    input limb_shift_t sh);
    return mk(DP_NOP, IDX_HOLD, 1'b1, ma, mb, sh, C_NEVER, PcIdle);
  endfunction

  // Control store.
  function automatic gds_ctrl_t rom(input pc_t pc);
    gds_ctrl_t w;
    unique case (pc)
      PcIdle:     w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_BUILD_REQ, PcInit);
      PcWait:     w = mk(DP_CAPTURE, IDX_CLR, 1'b0, 2'd0, 2'd0, 3'd0, C_NO_START, PcIdle);
      PcCheck:    w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_SPECIAL, PcOut);
      PcLoop:     w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_BIT_CLEAR, PcNext);
      PcLoad:     w = mk(DP_LOAD_B, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_FIRST, PcSetW);
      // Truncating 0.64 product of weight and ladder entry, low-by-low dropped.
      PcFm0:      w = mac(2'd1, 2'd0, 3'd1);
      PcFm1:      w = mac(2'd0, 2'd1, 3'd1);
      PcFm2:      w = mac(2'd1, 2'd1, 3'd2);
      PcFmDrain:  w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_NEVER, PcIdle);
      PcFmWb:     w = mk(DP_W_ACC, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_ALWAYS, PcNext);
      PcSetW:     w = mk(DP_SET_W, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_NEVER, PcIdle);
      PcNext:     w = mk(DP_NOP, IDX_INC, 1'b0, 2'd0, 2'd0, 3'd0, C_NOT_LAST, PcLoop);
      // Full 64 x 64 product of magnitude and weight, top half kept.
      PcScale:    w = mk(DP_SCALE_LD, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_NEVER, PcIdle);
      PcSm0:      w = mac(2'd0, 2'd0, 3'd0);
      PcSm1:      w = mac(2'd1, 2'd0, 3'd1);
      PcSm2:      w = mac(2'd0, 2'd1, 3'd1);
      PcSm3:      w = mac(2'd1, 2'd1, 3'd2);
      PcSmDrain:  w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_NEVER, PcIdle);
      PcOut:      w = mk(DP_OUT, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_OUT_FREE, PcIdle);
      PcOutHold:  w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_ALWAYS, PcOut);
      // Ladder build: write an entry, then square the 96-bit fraction exactly.
      PcInit:     w = mk(DP_INIT_C, IDX_CLR, 1'b0, 2'd0, 2'd0, 3'd0, C_NEVER, PcIdle);
      PcLadderWr: w = mk(DP_LADDER_WR, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_LAST, PcIdle);
      PcSq0:      w = mac(2'd0, 2'd0, 3'd0);
      PcSq1:      w = mac(2'd0, 2'd1, 3'd1);
      PcSq2:      w = mac(2'd0, 2'd2, 3'd2);
      PcSq3:      w = mac(2'd1, 2'd0, 3'd1);
      PcSq4:      w = mac(2'd1, 2'd1, 3'd2);
      PcSq5:      w = mac(2'd1, 2'd2, 3'd3);
      PcSq6:      w = mac(2'd2, 2'd0, 3'd2);
      PcSq7:      w = mac(2'd2, 2'd1, 3'd3);
      PcSq8:      w = mac(2'd2, 2'd2, 3'd4);
      PcSqDrain:  w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_NEVER, PcIdle);
      PcSqWb:     w = mk(DP_C_ACC, IDX_INC, 1'b0, 2'd0, 2'd0, 3'd0, C_ALWAYS, PcLadderWr);
      default:    w = mk(DP_NOP, IDX_HOLD, 1'b0, 2'd0, 2'd0, 3'd0, C_ALWAYS, PcIdle);
    endcase
    return w;
  endfunction

  pc_t       pc_q, pc_d;
  gds_ctrl_t ctrl;
  logic      take;

  assign ctrl   = rom(pc_q);
  assign ctrl_o = ctrl;

  // Jump condition of the current step.
  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_BUILD_REQ: take = status_i.build_req;
      C_NO_START:  take = ~status_i.start;
      C_SPECIAL:   take = status_i.special;
      C_BIT_CLEAR: take = status_i.bit_clear;
      C_FIRST:     take = status_i.first;
      C_NOT_LAST:  take = ~status_i.last;
      C_LAST:      take = status_i.last;
      C_OUT_FREE:  take = ~status_i.out_busy;
      default:     take = 1'b0;
    endcase
  end

  assign pc_d = take ? ctrl.target : pc_t'(pc_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* hw/rtl/gds_datapath.sv */
// Datapath: operand and accumulator registers, one shared 32x32 multiplier, the power
// ladder, the decay shift register and the result register. Depends on gds_pkg.
module gds_datapath #(
  parameter int unsigned LadderSteps = gds_pkg::LADDER_STEPS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gds_pkg::gds_ctrl_t               ctrl_i,
  output gds_pkg::gds_status_t             status_o,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [gds_pkg::DataW-1:0] value_i,
  input  logic        [gds_pkg::DistW-1:0] distance_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [gds_pkg::DataW-1:0] adjusted_value_o,
  input  logic                             cfg_we_i,
  input  logic        [gds_pkg::CfgW-1:0]  cfg_wdata_i
);
  import gds_pkg::*;

  localparam int unsigned IdxW = (LadderSteps > 1) ? $clog2(LadderSteps) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(LadderSteps - 1);

  // Picks one 32-bit limb of a 96-bit operand.
  function automatic logic [LimbW-1:0] limb(input logic [GuardW-1:0] v, input limb_sel_t s);
    logic [LimbW-1:0] r;
    unique case (s)
      2'd0:    r = v[LimbW-1:0];
      2'd1:    r = v[2*LimbW-1:LimbW];
      2'd2:    r = v[3*LimbW-1:2*LimbW];
      default: r = '0;
    endcase
    return r;
  endfunction

  // Control state.
  logic [CfgW-1:0]  k_q;
  logic             build_req_q, build_req_d;
  logic             first_q, first_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             prod_vld_q;
  logic             out_valid_q, out_valid_d;

  // Payload state.
  logic [DataW-1:0]       value_q;
  logic [LadderSteps-1:0] dist_q;
  logic                   zero_q, big_q;
  logic [GuardW-1:0]      a_q, a_d, b_q, b_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [ProdW-1:0]       prod_q;
  limb_shift_t            prod_sh_q;
  logic [DataW-1:0]       out_data_q;
  logic [FracW-1:0]       ladder_q [LadderSteps];

  logic              in_fire, out_busy, out_load, acc_clr, idx_last;
  logic [CfgW-1:0]   k_sat;
  logic [GuardW-1:0] c_init;
  logic [AccW-1:0]   addend;
  logic [DataW-1:0]  mag, prod_top, result;

  // Input handshake: offered only in the capture step and never with a rebuild pending.
  assign in_ready_o = (ctrl_i.dp == DP_CAPTURE) && !build_req_q;
  assign in_fire    = in_valid_i && in_ready_o;

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (ctrl_i.dp == DP_OUT) && !out_busy;
  assign idx_last = (idx_q == IdxLast);
  assign acc_clr  = (ctrl_i.dp == DP_LOAD_B) || (ctrl_i.dp == DP_SCALE_LD) ||
                    (ctrl_i.dp == DP_LADDER_WR);

  always_comb begin
    status_o.build_req = build_req_q;
    status_o.start     = in_fire;
    status_o.special   = zero_q || big_q;
    status_o.bit_clear = !dist_q[idx_q];
    status_o.first     = first_q;
    status_o.last      = idx_last;
    status_o.out_busy  = out_busy;
  end

  // Starting fraction 1 - 2^-k with k held to the range one to 64.
  always_comb begin
    if (k_q < DecayShiftMin) begin
      k_sat = DecayShiftMin;
    end else if (k_q > DecayShiftMax) begin
      k_sat = DecayShiftMax;
    end else begin
      k_sat = k_q;
    end
    c_init = ~({GuardW{1'b1}} >> k_sat);
  end

  // Magnitude of the item, and the signed result from the top of the accumulator.
  assign mag      = value_q[DataW-1] ? (DataW'(0) - value_q) : value_q;
  assign prod_top = acc_q[2*FracW-1:FracW];

  always_comb begin
    priority if (zero_q) begin
      result = value_q;
    end else if (big_q) begin
      result = '0;
    end else if (value_q[DataW-1]) begin
      result = DataW'(0) - prod_top;
    end else begin
      result = prod_top;
    end
  end

  // Registered product placed at its limb weight.
  always_comb begin
    unique case (prod_sh_q)
      3'd0:    addend = {{(AccW-ProdW){1'b0}}, prod_q};
      3'd1:    addend = {{(AccW-ProdW-LimbW){1'b0}}, prod_q, {LimbW{1'b0}}};
      3'd2:    addend = {{(AccW-ProdW-2*LimbW){1'b0}}, prod_q, {(2*LimbW){1'b0}}};
      3'd3:    addend = {{(AccW-ProdW-3*LimbW){1'b0}}, prod_q, {(3*LimbW){1'b0}}};
      3'd4:    addend = {prod_q, {(4*LimbW){1'b0}}};
      default: addend = '0;
    endcase
  end

  // Accumulator: cleared at the start of each product, else adds the pending product.
  always_comb begin
    if (acc_clr) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + addend;
    end else begin
      acc_d = acc_q;
    end
  end

  // Operand registers.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    unique case (ctrl_i.dp)
      DP_LOAD_B:   b_d = {{(GuardW-FracW){1'b0}}, ladder_q[idx_q]};
      DP_SET_W:    a_d = b_q;
      DP_W_ACC:    a_d = {{(GuardW-FracW){1'b0}}, prod_top};
      DP_SCALE_LD: begin
        a_d = {{(GuardW-DataW){1'b0}}, mag};
        b_d = {{(GuardW-FracW){1'b0}}, a_q[FracW-1:0]};
      end
      DP_INIT_C: begin
        a_d = c_init;
        b_d = c_init;
      end
      DP_C_ACC: begin
        a_d = acc_q[AccW-1:GuardW];
        b_d = acc_q[AccW-1:GuardW];
      end
      default: begin
      end
    endcase
  end

  // Sequencer-side state: ladder index, first-bit flag, rebuild request, result valid.
  always_comb begin
    unique case (ctrl_i.idx_op)
      IDX_CLR: idx_d = '0;
      IDX_INC: idx_d = idx_last ? idx_q : idx_q + 1'b1;
      default: idx_d = idx_q;
    endcase

    first_d = first_q;
    if (in_fire) begin
      first_d = 1'b1;
    end else if (ctrl_i.dp == DP_SET_W) begin
      first_d = 1'b0;
    end

    build_req_d = build_req_q;
    if (cfg_we_i) begin
      build_req_d = 1'b1;
    end else if (ctrl_i.dp == DP_INIT_C) begin
      build_req_d = 1'b0;
    end

    out_valid_d = out_busy || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= DecayShiftRst;
      build_req_q <= 1'b1;
      first_q     <= 1'b0;
      idx_q       <= '0;
      prod_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      build_req_q <= build_req_d;
      first_q     <= first_d;
      idx_q       <= idx_d;
      prod_vld_q  <= ctrl_i.mul_en;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and the shared multiplier stage.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    if (ctrl_i.mul_en) begin
      prod_q    <= ProdW'(limb(a_q, ctrl_i.mul_a)) * ProdW'(limb(b_q, ctrl_i.mul_b));
      prod_sh_q <= ctrl_i.mul_sh;
    end
    if (in_fire) begin
      value_q <= value_i;
      dist_q  <= distance_i[LadderSteps-1:0];
      zero_q  <= (distance_i == '0);
      big_q   <= ((distance_i >> LadderSteps) != '0);
    end
    if (out_load) begin
      out_data_q <= result;
    end
  end

  // Power ladder storage: top 64 fraction bits of the current square.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.dp == DP_LADDER_WR) begin
      ladder_q[idx_q] <= a_q[GuardW-1:GuardW-FracW];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign adjusted_value_o = $signed(out_data_q);

endmodule

/* hw/rtl/gds_checker.sv */
// Port-level checks for the geometric decay scaler, and the bind that attaches them.
// Depends on gds_pkg and on the port names of geometric_decay_scaler.
module gds_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [gds_pkg::DataW-1:0] out_data_i,
  input logic                      cfg_we_i
);

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result data changed while stalled");

  // A decay shift write starts a ladder rebuild, so no item is taken right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("input offered right after a decay shift write");

  // After an input beat the block is busy and no result can appear in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i && !$rose(out_valid_i))
    else $error("input offered or result shown right after an input beat");

endmodule

bind geometric_decay_scaler gds_checker u_gds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.adjusted_value),
  .cfg_we_i    (cfg_we_i)
);
